FILE: src/sdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_pkg - shared types and constants of the shutter drive controller
// Codes, payload structs and the queue entry between front and back.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam logic [6:0] FULL_DUTY = 7'd100;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_OPEN   = 2'd1,
    KIND_CLOSE  = 2'd2,
    KIND_EXPOSE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ERROR    = 3'd0,
    ST_OPENED   = 3'd1,
    ST_CLOSED   = 3'd2,
    ST_MOVING   = 3'd3,
    ST_EXPOSING = 3'd4
  } st_code_t;

  typedef enum logic [1:0] {
    REG_MIN_VOLT  = 2'd0,
    REG_CHECK_HALL = 2'd1,
    REG_HOLD_DUTY = 2'd2,
    REG_MOVE_TIME = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] supply_voltage;
    logic        hall_open;
    logic        camera_active;
    logic [31:0] exposure_ms;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  shutter_status;
    logic [6:0]  drive_duty;
    logic        report_valid;
    logic        sensor_open;
    logic [31:0] exposure_set_ms;
    logic        open_extra_valid;
    logic [31:0] open_extra_ms;
    logic        cannot_close;
    logic        closed_unexpectedly;
  } out_item_t;

  // classified command handed from the front to the back
  typedef struct packed {
    logic        is_tick;
    logic [2:0]  want;
    logic        low_volt;
    logic        hall;
    logic        cam;
    logic [31:0] exposure_ms;
  } cmd_t;

endpackage

FILE: src/sdc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_front - input classification and command queue
// Decodes each item, compares the supply level, and queues it (depth 2).
// ----------------------------------------------------------------------------
module sdc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  sdc_pkg::in_item_t in_item,
  input  logic [15:0]       min_work_voltage,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output sdc_pkg::cmd_t     cmd
);

  sdc_pkg::cmd_t q [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;
  sdc_pkg::cmd_t cls;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    cls.is_tick     = (in_item.kind == sdc_pkg::KIND_TICK);
    case (in_item.kind)
      sdc_pkg::KIND_OPEN:   cls.want = sdc_pkg::ST_OPENED;
      sdc_pkg::KIND_CLOSE:  cls.want = sdc_pkg::ST_CLOSED;
      sdc_pkg::KIND_EXPOSE: cls.want = sdc_pkg::ST_EXPOSING;
      default:              cls.want = sdc_pkg::ST_ERROR;
    endcase
    cls.low_volt    = (in_item.supply_voltage < min_work_voltage);
    cls.hall        = in_item.hall_open;
    cls.cam         = in_item.camera_active;
    cls.exposure_ms = in_item.exposure_ms;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_take;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("command queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !do_pop)
    else $error("pop from empty command queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not grow on push");

endmodule

FILE: src/sdc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_back - shutter state machine and result register
// Runs one command per cycle while the output queue has room, and holds results in a two-entry output queue.
// ----------------------------------------------------------------------------
module sdc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  sdc_pkg::cmd_t      cmd,
  input  logic               check_hall,
  input  logic [6:0]         holding_duty,
  input  logic [15:0]        move_time_ms,
  output logic               empty,
  input  logic               pop,
  output sdc_pkg::out_item_t out_item
);

  logic [2:0]  current_state, current_state_next;
  logic [2:0]  target_state, target_state_next;
  logic [31:0] now_ms, now_ms_next;
  logic [31:0] phase_start_ms, phase_start_ms_next;
  logic [31:0] opened_at_ms, opened_at_ms_next;
  logic [31:0] exposure_length, exposure_length_next;
  logic        last_camera_level, last_camera_level_next;
  logic [6:0]  duty_now, duty_now_next;

  sdc_pkg::out_item_t oq [2];
  logic               rd_ptr, wr_ptr;
  logic [1:0]         count;
  sdc_pkg::out_item_t res;

  logic [6:0]  hold;
  logic [31:0] since, phase_el;
  logic [32:0] exp_lim;
  logic        go_ok, go2_ok, rep, stop;
  logic [2:0]  go_want;
  logic [2:0]  rep_state;

  assign hold     = (holding_duty > sdc_pkg::FULL_DUTY) ? sdc_pkg::FULL_DUTY : holding_duty;
  assign cmd_take = cmd_valid && (count != 2'd2);
  assign empty    = (count == 2'd0);
  assign out_item = oq[rd_ptr];

  always_comb begin
    current_state_next     = current_state;
    target_state_next      = target_state;
    now_ms_next            = cmd.is_tick ? now_ms + 32'd1 : now_ms;
    phase_start_ms_next    = phase_start_ms;
    opened_at_ms_next      = opened_at_ms;
    exposure_length_next   = exposure_length;
    last_camera_level_next = last_camera_level;
    duty_now_next          = duty_now;
    res                    = '0;
    res.accepted           = 1'b1;
    rep                    = 1'b0;
    stop                   = 1'b0;
    go_ok                  = 1'b0;
    go2_ok                 = 1'b0;
    go_want                = cmd.want;
    rep_state              = current_state;
    phase_el               = now_ms_next - phase_start_ms;
    exp_lim                = {1'b0, exposure_length} + {17'd0, move_time_ms};

    if (!cmd.is_tick) begin
      // command: one move request
      if (go_want == current_state && go_want == sdc_pkg::ST_CLOSED
          && (!check_hall || !cmd.hall)) begin
        go_ok = 1'b1;
      end else if (go_want == current_state && go_want == sdc_pkg::ST_OPENED
          && (!check_hall || cmd.hall)) begin
        go_ok = 1'b1;
      end else if (go_want == current_state && go_want == sdc_pkg::ST_EXPOSING) begin
        go_ok = 1'b0;
      end else if (cmd.low_volt) begin
        go_ok = 1'b0;
      end else begin
        go_ok = 1'b1;
        duty_now_next = (go_want == sdc_pkg::ST_CLOSED) ? 7'd0 : sdc_pkg::FULL_DUTY;
        current_state_next  = sdc_pkg::ST_MOVING;
        target_state_next   = go_want;
        phase_start_ms_next = now_ms;
      end
      res.accepted = go_ok;
      if (go_ok && go_want == sdc_pkg::ST_EXPOSING) exposure_length_next = cmd.exposure_ms;
    end else if (cmd.low_volt) begin
      current_state_next = sdc_pkg::ST_ERROR;
      stop = 1'b1;
    end else begin
      case (current_state)
        sdc_pkg::ST_ERROR: begin
          stop = 1'b1;
          if (target_state == sdc_pkg::ST_CLOSED) begin
            duty_now_next = 7'd0;
            current_state_next = sdc_pkg::ST_MOVING;
            phase_start_ms_next = now_ms_next;
          end else if (target_state == sdc_pkg::ST_OPENED
                       || target_state == sdc_pkg::ST_EXPOSING) begin
            duty_now_next = sdc_pkg::FULL_DUTY;
            current_state_next = sdc_pkg::ST_MOVING;
            phase_start_ms_next = now_ms_next;
          end else begin
            current_state_next = target_state;
          end
        end
        sdc_pkg::ST_MOVING: begin
          if (check_hall && (target_state == sdc_pkg::ST_OPENED
              || target_state == sdc_pkg::ST_EXPOSING) && cmd.hall) begin
            duty_now_next = hold;
            current_state_next = target_state;
            opened_at_ms_next = now_ms_next;
            phase_start_ms_next = now_ms_next;
            rep = 1'b1;
            stop = 1'b1;
          end else if (check_hall && target_state == sdc_pkg::ST_CLOSED && !cmd.hall) begin
            current_state_next = target_state;
            rep = 1'b1;
            stop = 1'b1;
          end else if (check_hall && target_state != sdc_pkg::ST_OPENED
              && target_state != sdc_pkg::ST_EXPOSING && target_state != sdc_pkg::ST_CLOSED)
          begin
            target_state_next = sdc_pkg::ST_CLOSED;
            current_state_next = sdc_pkg::ST_ERROR;
            rep = 1'b1;
            stop = 1'b1;
          end else if (phase_el >= {16'd0, move_time_ms}) begin
            rep = 1'b1;
            if (check_hall && target_state != sdc_pkg::ST_CLOSED) begin
              target_state_next = sdc_pkg::ST_CLOSED;
              current_state_next = sdc_pkg::ST_ERROR;
              stop = 1'b1;
            end else begin
              if (target_state == sdc_pkg::ST_OPENED
                  || target_state == sdc_pkg::ST_EXPOSING) begin
                duty_now_next = hold;
                opened_at_ms_next = now_ms_next;
              end
              current_state_next = target_state;
              phase_start_ms_next = now_ms_next;
            end
          end
        end
        sdc_pkg::ST_EXPOSING: begin
          if (phase_el >= exposure_length) begin
            if (!cmd.low_volt) begin
              duty_now_next = 7'd0;
              current_state_next = sdc_pkg::ST_MOVING;
              target_state_next = sdc_pkg::ST_CLOSED;
              phase_start_ms_next = now_ms_next;
            end else if ({1'b0, phase_el} >= exp_lim) begin
              res.cannot_close = 1'b1;
              target_state_next = sdc_pkg::ST_CLOSED;
              current_state_next = sdc_pkg::ST_ERROR;
            end
          end
        end
        default: begin
          if (check_hall) begin
            if (cmd.hall) begin
              if (current_state == sdc_pkg::ST_CLOSED) current_state_next = sdc_pkg::ST_ERROR;
            end else if (current_state == sdc_pkg::ST_OPENED) begin
              res.closed_unexpectedly = 1'b1;
              target_state_next = sdc_pkg::ST_CLOSED;
              current_state_next = sdc_pkg::ST_ERROR;
            end
          end
        end
      endcase

      // the report shows the state before any camera edge move
      rep_state = current_state_next;

      // camera enable edge follows from the updated state
      if (!stop && current_state_next != sdc_pkg::ST_ERROR
          && last_camera_level != cmd.cam) begin
        go_want = cmd.cam ? sdc_pkg::ST_OPENED : sdc_pkg::ST_CLOSED;
        if (go_want == current_state_next && (!check_hall || (cmd.hall == cmd.cam))) begin
          go2_ok = 1'b1;
        end else begin
          // supply already checked good on this tick
          go2_ok = 1'b1;
          duty_now_next = cmd.cam ? sdc_pkg::FULL_DUTY : 7'd0;
          current_state_next = sdc_pkg::ST_MOVING;
          target_state_next = go_want;
          phase_start_ms_next = now_ms_next;
        end
        last_camera_level_next = go2_ok ? cmd.cam : ~cmd.cam;
      end
    end

    since = now_ms_next - opened_at_ms_next;
    if (rep) begin
      res.report_valid = 1'b1;
      res.sensor_open  = check_hall & cmd.hall;
      res.exposure_set_ms = (rep_state == sdc_pkg::ST_EXPOSING)
                            ? exposure_length : 32'd0;
      if (since > {16'd0, move_time_ms}) begin
        res.open_extra_valid = 1'b1;
        res.open_extra_ms = since - {16'd0, move_time_ms};
      end
    end
    res.shutter_status = current_state_next;
    res.drive_duty     = duty_now_next;
  end

  always_ff @(posedge clk) begin
    if (cmd_take) oq[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_state     <= sdc_pkg::ST_CLOSED;
      target_state      <= sdc_pkg::ST_CLOSED;
      now_ms            <= '0;
      phase_start_ms    <= '0;
      opened_at_ms      <= '0;
      exposure_length   <= '0;
      last_camera_level <= 1'b0;
      duty_now          <= '0;
      rd_ptr            <= 1'b0;
      wr_ptr            <= 1'b0;
      count             <= 2'd0;
    end else begin
      if (cmd_take) begin
        current_state     <= current_state_next;
        target_state      <= target_state_next;
        now_ms            <= now_ms_next;
        phase_start_ms    <= phase_start_ms_next;
        opened_at_ms      <= opened_at_ms_next;
        exposure_length   <= exposure_length_next;
        last_camera_level <= last_camera_level_next;
        duty_now          <= duty_now_next;
        wr_ptr            <= ~wr_ptr;
      end
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, cmd_take} - {1'b0, pop && !empty};
    end
  end

  a_duty_range: assert property (@(posedge clk) disable iff (rst) duty_now <= sdc_pkg::FULL_DUTY)
    else $error("coil duty above full");
  a_moving_target: assert property (@(posedge clk) disable iff (rst)
    current_state == sdc_pkg::ST_MOVING && cmd_take && cmd.is_tick && !cmd.low_volt
    && check_hall && target_state == sdc_pkg::ST_CLOSED && !cmd.hall
    |=> current_state == sdc_pkg::ST_CLOSED)
    else $error("closing move not confirmed by hall");
  a_time_tick: assert property (@(posedge clk) disable iff (rst)
    cmd_take && !cmd.is_tick |=> $stable(now_ms))
    else $error("time advanced on a command");

endmodule

FILE: src/shutter_drive_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shutter_drive_controller_unit - camera shutter coil driver
// Tick and command transactions in, one status transaction out per item.
//
//  channel   signals                         direction
//  input     push, full, in_item             in
//  result    empty, pop, out_item            out
//  config    cfg_we, cfg_index, cfg_data     in
//
// One item per cycle while results are popped; an item passes through the
// command queue, then the state update into the result queue.
// Synchronous reset restores register defaults and closed state.
// A stalled result queue backs up the command queue, then raises full.
// ----------------------------------------------------------------------------
module shutter_drive_controller_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sdc_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output sdc_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0]   min_work_voltage;
  logic          check_hall;
  logic [6:0]    holding_duty;
  logic [15:0]   move_time_ms;
  logic          cmd_valid, cmd_take;
  sdc_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_work_voltage <= 16'd1000;
      check_hall       <= 1'b1;
      holding_duty     <= 7'd25;
      move_time_ms     <= 16'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        sdc_pkg::REG_MIN_VOLT:   min_work_voltage <= cfg_data;
        sdc_pkg::REG_CHECK_HALL: check_hall       <= cfg_data[0];
        sdc_pkg::REG_HOLD_DUTY:  holding_duty     <= cfg_data[6:0];
        sdc_pkg::REG_MOVE_TIME:  move_time_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  sdc_front u_front (
    .clk, .rst, .push, .full, .in_item, .min_work_voltage,
    .cmd_valid, .cmd_take, .cmd
  );

  sdc_back u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd, .check_hall, .holding_duty,
    .move_time_ms, .empty, .pop, .out_item
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench of the shutter drive controller unit
// Drives tick and command transactions through the push/full port and
// checks every status transaction against a cycle-free shutter predictor,
// under random sender bursts, receiver stalls and several register setups.
// ----------------------------------------------------------------------------
module tb;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  sdc_pkg::in_item_t   in_item = '0;
  logic                empty;
  logic                pop = 1'b0;
  sdc_pkg::out_item_t  out_item;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  shutter_drive_controller_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and shutter state
  logic [15:0] min_volt;
  logic        chk_hall;
  logic [6:0]  hold_cfg;
  logic [15:0] move_time;
  logic [2:0]  cur_st, tgt_st;
  logic [31:0] now_ms, phase_ms, opened_ms, exp_len;
  logic        last_cam;
  logic [6:0]  duty;
  logic [15:0] volt;
  logic        hall;
  sdc_pkg::out_item_t rep;

  sdc_pkg::out_item_t status_q[$];
  int          errors = 0;
  int          burst_left = 0;
  logic        cam_level = 1'b0;

  function automatic logic [6:0] hold_level();
    return (hold_cfg > sdc_pkg::FULL_DUTY) ? sdc_pkg::FULL_DUTY : hold_cfg;
  endfunction

  function automatic void fill_report();
    logic [31:0] since;
    since = now_ms - opened_ms;
    rep.report_valid = 1'b1;
    rep.sensor_open = chk_hall ? hall : 1'b0;
    rep.exposure_set_ms = (cur_st == sdc_pkg::ST_EXPOSING) ? exp_len : 32'd0;
    if (since > {16'd0, move_time}) begin
      rep.open_extra_valid = 1'b1;
      rep.open_extra_ms = since - {16'd0, move_time};
    end
  endfunction

  function automatic bit move_to(logic [2:0] want);
    if (want == sdc_pkg::ST_CLOSED && cur_st == want && (!chk_hall || !hall)) return 1;
    if (want == sdc_pkg::ST_OPENED && cur_st == want && (!chk_hall || hall)) return 1;
    if (want == sdc_pkg::ST_EXPOSING && cur_st == want) return 0;
    if (volt < min_volt) return 0;
    if (want == sdc_pkg::ST_EXPOSING || want == sdc_pkg::ST_OPENED) duty = sdc_pkg::FULL_DUTY;
    else if (want == sdc_pkg::ST_CLOSED) duty = 7'd0;
    else begin
      cur_st = want;
      return 1;
    end
    cur_st = sdc_pkg::ST_MOVING;
    tgt_st = want;
    phase_ms = now_ms;
    return 1;
  endfunction

  function automatic void fault_closed();
    tgt_st = sdc_pkg::ST_CLOSED;
    cur_st = sdc_pkg::ST_ERROR;
  endfunction

  function automatic void run_tick(logic cam);
    if (volt < min_volt) begin
      cur_st = sdc_pkg::ST_ERROR;
      return;
    end
    case (cur_st)
      sdc_pkg::ST_ERROR: begin
        void'(move_to(tgt_st));
        return;
      end
      sdc_pkg::ST_MOVING: begin
        if (chk_hall) begin
          if (tgt_st == sdc_pkg::ST_OPENED || tgt_st == sdc_pkg::ST_EXPOSING) begin
            if (hall) begin
              duty = hold_level();
              cur_st = tgt_st;
              opened_ms = now_ms;
              phase_ms = now_ms;
              fill_report();
              return;
            end
          end else if (tgt_st == sdc_pkg::ST_CLOSED) begin
            if (!hall) begin
              cur_st = tgt_st;
              fill_report();
              return;
            end
          end else begin
            fault_closed();
            fill_report();
            return;
          end
        end
        if (now_ms - phase_ms >= {16'd0, move_time}) begin
          if (chk_hall && tgt_st != sdc_pkg::ST_CLOSED) begin
            fault_closed();
            fill_report();
            return;
          end
          if (tgt_st == sdc_pkg::ST_OPENED || tgt_st == sdc_pkg::ST_EXPOSING) begin
            duty = hold_level();
            opened_ms = now_ms;
          end
          cur_st = tgt_st;
          phase_ms = now_ms;
          fill_report();
        end
      end
      sdc_pkg::ST_EXPOSING: begin
        if (now_ms - phase_ms >= exp_len) begin
          if (!move_to(sdc_pkg::ST_CLOSED)) begin
            if (now_ms - phase_ms >= exp_len + {16'd0, move_time}) begin
              rep.cannot_close = 1'b1;
              fault_closed();
            end
          end
        end
      end
      default: begin
        if (chk_hall) begin
          if (hall) begin
            if (cur_st == sdc_pkg::ST_CLOSED) cur_st = sdc_pkg::ST_ERROR;
          end else if (cur_st == sdc_pkg::ST_OPENED) begin
            rep.closed_unexpectedly = 1'b1;
            fault_closed();
          end
        end
      end
    endcase
    if (cur_st == sdc_pkg::ST_ERROR) return;
    if (last_cam == cam) return;
    if (cam) begin
      if (!move_to(sdc_pkg::ST_OPENED)) begin
        last_cam = 1'b0;
        return;
      end
    end else if (!move_to(sdc_pkg::ST_CLOSED)) begin
      last_cam = 1'b1;
      return;
    end
    last_cam = cam;
  endfunction

  function automatic sdc_pkg::out_item_t predict_status(sdc_pkg::in_item_t it);
    rep = '0;
    rep.accepted = 1'b1;
    volt = it.supply_voltage;
    hall = it.hall_open;
    case (sdc_pkg::kind_t'(it.kind))
      sdc_pkg::KIND_TICK: begin
        now_ms = now_ms + 32'd1;
        run_tick(it.camera_active);
      end
      sdc_pkg::KIND_OPEN:  rep.accepted = move_to(sdc_pkg::ST_OPENED);
      sdc_pkg::KIND_CLOSE: rep.accepted = move_to(sdc_pkg::ST_CLOSED);
      default: begin
        rep.accepted = 1'b0;
        if (move_to(sdc_pkg::ST_EXPOSING)) begin
          exp_len = it.exposure_ms;
          rep.accepted = 1'b1;
        end
      end
    endcase
    rep.shutter_status = cur_st;
    rep.drive_duty = duty;
    return rep;
  endfunction

  // one item; the sender pauses between bursts of random length
  task automatic send_item(sdc_pkg::in_item_t it);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    status_q.push_back(predict_status(it));
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    burst_left = 0;
    while (status_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(sdc_pkg::reg_idx_t idx, logic [15:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sdc_pkg::REG_MIN_VOLT:   min_volt = value;
      sdc_pkg::REG_CHECK_HALL: chk_hall = value[0];
      sdc_pkg::REG_HOLD_DUTY:  hold_cfg = value[6:0];
      default:                 move_time = value;
    endcase
  endtask

  function automatic sdc_pkg::in_item_t make_item(sdc_pkg::kind_t k, logic [15:0] v,
                                                  logic h, logic c, logic [31:0] e);
    sdc_pkg::in_item_t it;
    it.kind = k;
    it.supply_voltage = v;
    it.hall_open = h;
    it.camera_active = c;
    it.exposure_ms = e;
    return it;
  endfunction

  task automatic test_directed();
    write_reg(sdc_pkg::REG_MOVE_TIME, 16'd2);
    write_reg(sdc_pkg::REG_HOLD_DUTY, 16'd127);   // saturates at full duty
    send_item(make_item(sdc_pkg::KIND_OPEN, 16'hFFFF, 1'b0, 1'b0, 32'd0));
    send_item(make_item(sdc_pkg::KIND_TICK, 16'hFFFF, 1'b1, 1'b0, 32'd0));
    // hall lost while open
    send_item(make_item(sdc_pkg::KIND_TICK, 16'hFFFF, 1'b0, 1'b0, 32'd0));
    // undervoltage
    send_item(make_item(sdc_pkg::KIND_TICK, 16'd0, 1'b0, 1'b0, 32'd0));
    // refused
    send_item(make_item(sdc_pkg::KIND_OPEN, 16'd0, 1'b0, 1'b0, 32'd0));
    // retry from error
    send_item(make_item(sdc_pkg::KIND_TICK, 16'd5000, 1'b0, 1'b0, 32'd0));
    send_item(make_item(sdc_pkg::KIND_TICK, 16'd5000, 1'b0, 1'b0, 32'd0));
    send_item(make_item(sdc_pkg::KIND_EXPOSE, 16'd5000, 1'b0, 1'b0, 32'hFFFF_FFFF));
    // second exposure while still moving to exposing
    send_item(make_item(sdc_pkg::KIND_EXPOSE, 16'd5000, 1'b0, 1'b0, 32'd3));
    send_item(make_item(sdc_pkg::KIND_TICK, 16'd5000, 1'b1, 1'b0, 32'd0));
    send_item(make_item(sdc_pkg::KIND_TICK, 16'd5000, 1'b1, 1'b0, 32'd0));
    write_reg(sdc_pkg::REG_HOLD_DUTY, 16'd0);
    write_reg(sdc_pkg::REG_CHECK_HALL, 16'd0);
    send_item(make_item(sdc_pkg::KIND_CLOSE, 16'd5000, 1'b1, 1'b0, 32'd0));
    repeat (3) send_item(make_item(sdc_pkg::KIND_TICK, 16'd5000, 1'b1, 1'b0, 32'd0));
    send_item(make_item(sdc_pkg::KIND_EXPOSE, 16'd5000, 1'b0, 1'b0, 32'd0));
    repeat (4) send_item(make_item(sdc_pkg::KIND_TICK, 16'd5000, 1'b0, 1'b0, 32'd0));
    // camera rising
    send_item(make_item(sdc_pkg::KIND_TICK, 16'd5000, 1'b0, 1'b1, 32'd0));
    repeat (3) send_item(make_item(sdc_pkg::KIND_TICK, 16'd5000, 1'b1, 1'b1, 32'd0));
    // camera falling
    send_item(make_item(sdc_pkg::KIND_TICK, 16'd5000, 1'b1, 1'b0, 32'd0));
    send_item(make_item(sdc_pkg::KIND_TICK, 16'd5000, 1'b0, 1'b0, 32'd0));
  endtask

  task automatic test_random(int count, int full_rate);
    sdc_pkg::in_item_t it;
    bit phys;
    for (int n = 0; n < count; n++) begin
      phys = (cur_st == sdc_pkg::ST_OPENED || cur_st == sdc_pkg::ST_EXPOSING);
      if (cur_st == sdc_pkg::ST_MOVING)
        phys = $urandom_range(1) ? (tgt_st != sdc_pkg::ST_CLOSED) : 1'b0;
      it.hall_open = ($urandom_range(11) == 0) ? ~phys : phys;
      if ($urandom_range(19) == 0) it.supply_voltage = 16'($urandom_range(65535));
      else if ($urandom_range(24) == 0) it.supply_voltage = min_volt - 16'd1;
      else it.supply_voltage = (min_volt > 16'hFF00) ? 16'hFFFF
                               : min_volt + 16'($urandom_range(255));
      if ($urandom_range(15) == 0) cam_level = ~cam_level;
      it.camera_active = cam_level;
      case ($urandom_range(9))
        0: it.kind = sdc_pkg::KIND_OPEN;
        1: it.kind = sdc_pkg::KIND_CLOSE;
        2: it.kind = sdc_pkg::KIND_EXPOSE;
        default: it.kind = sdc_pkg::KIND_TICK;
      endcase
      it.exposure_ms = ($urandom_range(full_rate) == 0) ? $urandom : $urandom_range(40);
      send_item(it);
    end
  endtask

  task automatic test_settings();
    write_reg(sdc_pkg::REG_HOLD_DUTY, 16'd25);
    write_reg(sdc_pkg::REG_CHECK_HALL, 16'd1);
    write_reg(sdc_pkg::REG_MOVE_TIME, 16'd20);
    write_reg(sdc_pkg::REG_MIN_VOLT, 16'd1000);
    test_random(150, 9);
    write_reg(sdc_pkg::REG_MOVE_TIME, 16'd0);
    write_reg(sdc_pkg::REG_MIN_VOLT, 16'd0);
    test_random(120, 9);
    write_reg(sdc_pkg::REG_CHECK_HALL, 16'd0);
    write_reg(sdc_pkg::REG_MOVE_TIME, 16'd5);
    write_reg(sdc_pkg::REG_HOLD_DUTY, 16'd100);
    test_random(150, 9);
    write_reg(sdc_pkg::REG_MIN_VOLT, 16'hFFFF);
    test_random(80, 3);
    write_reg(sdc_pkg::REG_MIN_VOLT, 16'd30000);
    write_reg(sdc_pkg::REG_MOVE_TIME, 16'hFFFF);
    test_random(80, 3);
    write_reg(sdc_pkg::REG_CHECK_HALL, 16'd1);
    write_reg(sdc_pkg::REG_MOVE_TIME, 16'd3);
    write_reg(sdc_pkg::REG_HOLD_DUTY, 16'd1);
    test_random(200, 9);
    write_reg(sdc_pkg::REG_MOVE_TIME, 16'hFFFF);
    test_random(60, 3);
  endtask

  // receiver: free-running, random, or long stalls, switching now and then
  int pop_mode = 0;
  int pop_left = 0;
  always @(negedge clk) begin
    if (pop_left == 0) begin
      pop_mode = $urandom_range(2);
      pop_left = $urandom_range(5, 60);
    end
    pop_left--;
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(1));
      default: pop <= ($urandom_range(15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %p", $realtime,
                 out_item);
        errors++;
      end else begin
        if (out_item !== status_q[0]) begin
          $display("%0t: mismatch, expected %p, actual %p", $realtime, status_q[0],
                   out_item);
          errors++;
        end
        void'(status_q.pop_front());
      end
    end
  end

  initial begin
    min_volt = 16'd1000;
    chk_hall = 1'b1;
    hold_cfg = 7'd25;
    move_time = 16'd20;
    cur_st = sdc_pkg::ST_CLOSED;
    tgt_st = sdc_pkg::ST_CLOSED;
    now_ms = '0;
    phase_ms = '0;
    opened_ms = '0;
    exp_len = '0;
    last_cam = 1'b0;
    duty = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_settings();
    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && status_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
